/* rtl/core/urm_pkg.sv */
// Shared types and constants for the ultrasonic ranger with median-of-three filter.
package urm_pkg;

  // Field widths
  localparam int TIME_W   = 20;
  localparam int SAMPLE_W = TIME_W + 1;
  localparam int DIST_W   = 18;
  localparam int TRIG_W   = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // Distance scale: mm = time * DIST_MUL >> DIST_SHIFT
  localparam int DIST_MUL_W = 14;
  localparam logic [DIST_MUL_W-1:0] DIST_MUL = 14'd11272;
  localparam int DIST_SHIFT = 16;

  // Sample with the top bit set marks no echo
  typedef logic [SAMPLE_W-1:0] sample_t;
  localparam sample_t NO_ECHO = {1'b1, {TIME_W{1'b0}}};

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ECHO_TIMEOUT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP          = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BUSY_WAIT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIG_HIGH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIG_LOW     = 3'd5;

  typedef struct packed {
    logic [TIME_W-1:0] echo_timeout_us;
    logic [TIME_W-1:0] gap_us;
    logic [TIME_W-1:0] busy_wait_us;
    logic              filter_enable;
    logic [TRIG_W-1:0] trigger_high_us;
    logic [TRIG_W-1:0] trigger_low_us;
  } cfg_t;

  typedef struct packed {
    logic echo_level;
    logic start_req;
  } in_word_t;

  typedef struct packed {
    logic              trigger_level;
    logic              busy_res;
    logic              done_res;
    logic [TIME_W-1:0] echo_time;
    logic              no_echo;
    logic [DIST_W-1:0] distance_mm;
  } out_word_t;

  // Per-tick status handed from the sequencer to the output stage
  typedef struct packed {
    logic    trigger_level;
    logic    busy_res;
    logic    done_res;
    sample_t result;
  } step_word_t;

endpackage

/* rtl/core/urm_ping_ctrl.sv */
// Ping sequencer: one tick of trigger, echo timing and median filter per word.
module urm_ping_ctrl #(
  parameter int COUNT_WIDTH = 20
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  urm_pkg::in_word_t   req,
  input  urm_pkg::cfg_t       cfg,
  output urm_pkg::step_word_t step
);

  localparam int LW = (COUNT_WIDTH > urm_pkg::TIME_W) ? COUNT_WIDTH : urm_pkg::TIME_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [1:0] LAST_SAMPLE = 2'd2;

  typedef enum logic [3:0] {
    PH_IDLE, PH_START, PH_BUSYW, PH_TLOW1, PH_THIGH, PH_TLOW2, PH_WAITR, PH_MEAS, PH_GAP
  } phase_t;

  phase_t                  phase, phase_next;
  logic [COUNT_WIDTH-1:0]  phase_counter, phase_counter_next;
  logic [COUNT_WIDTH-1:0]  pulse_counter, pulse_counter_next;
  logic [1:0]              sample_index, sample_index_next;
  urm_pkg::sample_t        result_time, result_time_next;
  urm_pkg::sample_t        sample_store [2];
  urm_pkg::step_word_t     step_next;

  phase_t                  ph;
  logic [COUNT_WIDTH-1:0]  pc_cur, pc_inc;
  logic [COUNT_WIDTH-1:0]  len_busy, len_low, len_high, len_tmo, len_gap;
  logic [urm_pkg::TIME_W-1:0] tmo_raw;
  logic [LW-1:0]           pulse_ext;
  logic                    fin;
  urm_pkg::sample_t        fin_s;

  function automatic logic [COUNT_WIDTH-1:0] clamp_len(input logic [urm_pkg::TIME_W-1:0] len);
    logic [LW-1:0] len_ext;
    len_ext = LW'(len);
    if (len_ext > LW'(CNT_MAX)) begin
      return CNT_MAX;
    end
    return COUNT_WIDTH'(len_ext);
  endfunction

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
  endfunction

  function automatic urm_pkg::sample_t median3(input urm_pkg::sample_t a,
                                              input urm_pkg::sample_t b,
                                              input urm_pkg::sample_t c);
    urm_pkg::sample_t lo, hi, mid;
    lo  = (a < b) ? a : b;
    hi  = (a < b) ? b : a;
    mid = (hi < c) ? hi : c;
    return (lo > mid) ? lo : mid;
  endfunction

  // Clamp phase lengths to the counter range; a zero echo timeout is taken as one
  assign tmo_raw  = (cfg.echo_timeout_us == '0) ? urm_pkg::TIME_W'(1) : cfg.echo_timeout_us;
  assign len_busy = clamp_len(cfg.busy_wait_us);
  assign len_low  = clamp_len(urm_pkg::TIME_W'(cfg.trigger_low_us));
  assign len_high = clamp_len(urm_pkg::TIME_W'(cfg.trigger_high_us));
  assign len_tmo  = clamp_len(tmo_raw);
  assign len_gap  = clamp_len(cfg.gap_us);
  assign pulse_ext = LW'(pulse_counter);

  // Next state for one tick
  always_comb begin
    ph = phase;
    pc_cur = phase_counter;
    fin = 1'b0;
    fin_s = urm_pkg::NO_ECHO;
    step_next.trigger_level = 1'b0;
    step_next.done_res = 1'b0;
    pulse_counter_next = pulse_counter;
    sample_index_next = sample_index;
    result_time_next = result_time;

    if (ph == PH_IDLE && req.start_req) begin
      ph = PH_START;
    end
    step_next.busy_res = (ph != PH_IDLE);
    if (ph == PH_START) begin
      ph = req.echo_level ? PH_BUSYW : PH_TLOW1;
      pc_cur = '0;
    end
    pc_inc = sat_inc(pc_cur);
    phase_next = ph;
    phase_counter_next = pc_cur;

    case (ph)
      PH_BUSYW: begin
        phase_counter_next = pc_inc;
        if (pc_inc >= len_busy) begin
          fin = 1'b1;
        end
      end
      PH_TLOW1: begin
        phase_counter_next = pc_inc;
        if (pc_inc >= len_low) begin
          phase_next = PH_THIGH;
          phase_counter_next = '0;
        end
      end
      PH_THIGH: begin
        step_next.trigger_level = 1'b1;
        phase_counter_next = pc_inc;
        if (pc_inc >= len_high) begin
          phase_next = PH_TLOW2;
          phase_counter_next = '0;
        end
      end
      PH_TLOW2: begin
        phase_counter_next = pc_inc;
        if (pc_inc >= len_low) begin
          phase_next = PH_WAITR;
          phase_counter_next = '0;
          pulse_counter_next = '0;
        end
      end
      PH_WAITR: begin
        if (req.echo_level) begin
          pulse_counter_next = COUNT_WIDTH'(1);
          phase_next = PH_MEAS;
        end
        phase_counter_next = pc_inc;
        if (pc_inc >= len_tmo) begin
          fin = 1'b1;
        end
      end
      PH_MEAS: begin
        if (!req.echo_level) begin
          fin = 1'b1;
          fin_s = {1'b0, pulse_ext[urm_pkg::TIME_W-1:0]};
        end else begin
          pulse_counter_next = sat_inc(pulse_counter);
          phase_counter_next = pc_inc;
          if (pc_inc >= len_tmo) begin
            fin = 1'b1;
          end
        end
      end
      PH_GAP: begin
        phase_counter_next = pc_inc;
        if (pc_inc >= len_gap) begin
          phase_next = PH_START;
          phase_counter_next = '0;
        end
      end
      default: begin
      end
    endcase

    // End of ping: store the sample, then report or go on to the next ping
    if (fin) begin
      step_next.done_res = 1'b1;
      phase_counter_next = '0;
      if (!cfg.filter_enable) begin
        result_time_next = fin_s;
        sample_index_next = '0;
        phase_next = PH_IDLE;
      end else if (sample_index == LAST_SAMPLE) begin
        result_time_next = median3(sample_store[0], sample_store[1], fin_s);
        sample_index_next = '0;
        phase_next = PH_IDLE;
      end else begin
        sample_index_next = sample_index + 1'b1;
        phase_next = (cfg.gap_us == '0) ? PH_START : PH_GAP;
      end
    end
    step_next.result = result_time_next;
  end

  // Hold sequencer state and the registered step word
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      phase_counter <= '0;
      pulse_counter <= '0;
      sample_index <= '0;
      result_time <= urm_pkg::NO_ECHO;
    end else if (adv) begin
      phase <= phase_next;
      phase_counter <= phase_counter_next;
      pulse_counter <= pulse_counter_next;
      sample_index <= sample_index_next;
      result_time <= result_time_next;
      step <= step_next;
    end
  end

  // Sample store for the first two pings of a filtered sequence
  always_ff @(posedge clk) begin
    if (adv && fin && sample_index != LAST_SAMPLE) begin
      sample_store[sample_index[0]] <= fin_s;
    end
  end

`ifndef SYNTH
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    (adv && step_next.done_res) |-> step_next.busy_res)
    else $error("done without busy");
  a_idle_stays: assert property (@(posedge clk) disable iff (rst)
    (adv && phase == PH_IDLE && !req.start_req) |=> (phase == PH_IDLE))
    else $error("left idle without start");
  a_trig_phase: assert property (@(posedge clk) disable iff (rst)
    (adv && step_next.trigger_level) |-> (phase == PH_THIGH))
    else $error("trigger high outside trigger phase");
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    sample_index <= LAST_SAMPLE)
    else $error("sample index out of range");
`endif

endmodule

/* rtl/core/urm_range_out.sv */
// Output stage: converts the held result to time, no-echo flag and distance.
module urm_range_out (
  input  logic                clk,
  input  logic                adv,
  input  urm_pkg::step_word_t step,
  output urm_pkg::out_word_t  word
);

  localparam int PROD_W = urm_pkg::TIME_W + urm_pkg::DIST_MUL_W;

  logic                       noe;
  logic [urm_pkg::TIME_W-1:0] t;
  logic [PROD_W-1:0]          prod;

  // Scale echo time to millimetres
  assign noe  = step.result[urm_pkg::TIME_W];
  assign t    = noe ? '0 : step.result[urm_pkg::TIME_W-1:0];
  assign prod = PROD_W'(t) * PROD_W'(urm_pkg::DIST_MUL);

  // Load the result word
  always_ff @(posedge clk) begin
    if (adv) begin
      word.trigger_level <= step.trigger_level;
      word.busy_res <= step.busy_res;
      word.done_res <= step.done_res;
      word.echo_time <= t;
      word.no_echo <= noe;
      word.distance_mm <= prod[urm_pkg::DIST_SHIFT +: urm_pkg::DIST_W];
    end
  end

endmodule

/* rtl/core/ultrasonic_ranger_median3.sv */
// Top level of the ultrasonic ranger with median-of-three filter.
//
//   channel  direction  handshake            word
//   req      in         req_valid/req_stall  urm_pkg::in_word_t (echo level, start)
//   rsp      out        rsp_valid/rsp_stall  urm_pkg::out_word_t (trigger, status, range)
//   cfg      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// While rsp is not stalled, one word per cycle is taken and one result word per word is given.
// A word passes an input register, the sequencer register and the output
// register in that order; a stall on rsp can hold it in any of them.
// rst (synchronous) clears sequencer state and valid flags, sets cfg defaults.
// A stall on rsp holds the output register; empty stages ahead of it keep
// filling, and req_stall rises only when all three stages are full.
module ultrasonic_ranger_median3 #(
  parameter int COUNT_WIDTH = 20
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  urm_pkg::in_word_t                   req_word,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output urm_pkg::out_word_t                  rsp_word,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [urm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [urm_pkg::CFG_DATA_W-1:0]      cfg_data
);

  urm_pkg::cfg_t       cfg;
  urm_pkg::in_word_t   in_reg;
  urm_pkg::step_word_t step;
  logic                in_full, step_full;
  logic                out_free, step_free, in_free;
  logic                adv_in, adv_step, adv_out;

  // Stage handshake
  assign out_free  = !rsp_valid || !rsp_stall;
  assign adv_out   = step_full && out_free;
  assign step_free = !step_full || out_free;
  assign adv_step  = in_full && step_free;
  assign in_free   = !in_full || step_free;
  assign req_stall = !in_free;
  assign adv_in    = req_valid && in_free;
  assign cfg_ready = 1'b1;

  // Advance stage valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
      step_full <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (adv_in) begin
        in_full <= 1'b1;
      end else if (adv_step) begin
        in_full <= 1'b0;
      end
      if (adv_step) begin
        step_full <= 1'b1;
      end else if (adv_out) begin
        step_full <= 1'b0;
      end
      if (adv_out) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Hold the input word
  always_ff @(posedge clk) begin
    if (adv_in) begin
      in_reg <= req_word;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.echo_timeout_us <= urm_pkg::TIME_W'(50000);
      cfg.gap_us <= urm_pkg::TIME_W'(50000);
      cfg.busy_wait_us <= urm_pkg::TIME_W'(25000);
      cfg.filter_enable <= 1'b1;
      cfg.trigger_high_us <= urm_pkg::TRIG_W'(15);
      cfg.trigger_low_us <= urm_pkg::TRIG_W'(5);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        urm_pkg::CFG_ECHO_TIMEOUT: cfg.echo_timeout_us <= cfg_data[urm_pkg::TIME_W-1:0];
        urm_pkg::CFG_GAP:          cfg.gap_us <= cfg_data[urm_pkg::TIME_W-1:0];
        urm_pkg::CFG_BUSY_WAIT:    cfg.busy_wait_us <= cfg_data[urm_pkg::TIME_W-1:0];
        urm_pkg::CFG_FILTER:       cfg.filter_enable <= cfg_data[0];
        urm_pkg::CFG_TRIG_HIGH:    cfg.trigger_high_us <= cfg_data[urm_pkg::TRIG_W-1:0];
        urm_pkg::CFG_TRIG_LOW:     cfg.trigger_low_us <= cfg_data[urm_pkg::TRIG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  urm_ping_ctrl #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_ping_ctrl (
    .clk  (clk),
    .rst  (rst),
    .adv  (adv_step),
    .req  (in_reg),
    .cfg  (cfg),
    .step (step)
  );

  urm_range_out u_range_out (
    .clk  (clk),
    .adv  (adv_out),
    .step (step),
    .word (rsp_word)
  );

endmodule
